[design/pmt_pkg.sv]
// ----------------------------------------------------------------------------
// pmt_pkg: shared types and constants for the program map section parser
// Holds the parse phase encoding, header and result records, and the
// result builder used by the parse core.
// ----------------------------------------------------------------------------
package pmt_pkg;

  // Result queue depth; a power of two so the pointers wrap on their own.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] TELETEXT_TAG_RESET = 8'h56;

  // Header byte positions within the section
  localparam logic [11:0] OFS_LEN_HI  = 12'd1;
  localparam logic [11:0] OFS_LEN_LO  = 12'd2;
  localparam logic [11:0] OFS_PROG_HI = 12'd3;
  localparam logic [11:0] OFS_PROG_LO = 12'd4;
  localparam logic [11:0] OFS_VERSION = 12'd5;
  localparam logic [11:0] OFS_SECTION = 12'd6;
  localparam logic [11:0] OFS_LAST    = 12'd7;
  localparam logic [11:0] OFS_PCR_HI  = 12'd8;
  localparam logic [11:0] OFS_PCR_LO  = 12'd9;
  localparam logic [11:0] OFS_PIL_HI  = 12'd10;
  localparam logic [11:0] OFS_MAX     = 12'hFFF;

  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [8:0] {
    PH_IDLE    = 9'b000000001,
    PH_HEADER  = 9'b000000010,
    PH_TYPE    = 9'b000000100,
    PH_PID_HI  = 9'b000001000,
    PH_PID_LO  = 9'b000010000,
    PH_LEN_HI  = 9'b000100000,
    PH_LEN_LO  = 9'b001000000,
    PH_DESC    = 9'b010000000,
    PH_SKIP    = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [7:0]  tbl_id;
    logic [15:0] prog_num;
    logic [4:0]  ver_num;
    logic        current_next;
    logic [7:0]  sec_num;
    logic [7:0]  last_sec_num;
    logic [12:0] pcr_pid;
  } hdr_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  type_or_tid;
    logic [12:0] pid;
    logic [11:0] info_length;
    logic [15:0] prog_num;
    logic [4:0]  ver_num;
    logic        current_next;
    logic [7:0]  sec_num;
    logic [7:0]  last_sec_num;
    logic [11:0] sect_len;
    logic [7:0]  stream_count;
    logic        teletext_found;
  } result_t;

  // Results produced by one parsed byte: first alone, or an entry then a summary
  typedef struct packed {
    logic    first;
    logic    second;
    result_t a;
    result_t b;
  } push_t;

  function automatic result_t make_result(
    input logic        kind,
    input logic [7:0]  id,
    input logic [12:0] pid,
    input logic [11:0] len,
    input hdr_t        h,
    input logic [11:0] sec_len,
    input logic [7:0]  count,
    input logic        tt
  );
    result_t r;
    r.item_kind      = kind;
    r.type_or_tid    = id;
    r.pid            = pid;
    r.info_length    = len;
    r.prog_num       = h.prog_num;
    r.ver_num        = h.ver_num;
    r.current_next   = h.current_next;
    r.sec_num        = h.sec_num;
    r.last_sec_num   = h.last_sec_num;
    r.sect_len       = sec_len;
    r.stream_count   = count;
    r.teletext_found = tt;
    return r;
  endfunction

endpackage

[design/pmt_parse_core.sv]
// ----------------------------------------------------------------------------
// pmt_parse_core: section parse state and per-byte decode
// Consumes one registered byte per fire and produces up to two results.
// ----------------------------------------------------------------------------
module pmt_parse_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  input  logic                fire,
  input  logic [7:0]          data_byte,
  input  logic                section_start,
  output pmt_pkg::push_t      push
);

  logic [7:0]       tag;
  pmt_pkg::phase_t  phase, phase_next;
  logic [11:0]      offset, offset_next;
  logic [11:0]      total_len, total_len_next;
  logic [11:0]      pil, pil_next;
  pmt_pkg::hdr_t    hdr, hdr_next;
  logic [7:0]       ent_type, ent_type_next;
  logic [12:0]      ent_pid, ent_pid_next;
  logic [11:0]      skip, skip_next;
  logic [7:0]       count, count_next;
  logic             tt, tt_next;

  logic [11:0]      pil_full;
  logic [11:0]      es_len;
  logic [11:0]      skip_dec;
  logic [7:0]       count_inc;
  logic             tt_new;

  assign pil_full  = {pil[11:8], data_byte};
  assign es_len    = {skip[11:8], data_byte};
  assign skip_dec  = skip - 12'd1;
  assign count_inc = (count == 8'hFF) ? count : count + 8'd1;
  assign tt_new    = tt | (data_byte == tag);

  always_comb begin
    phase_next     = phase;
    offset_next    = offset;
    total_len_next = total_len;
    pil_next       = pil;
    hdr_next       = hdr;
    ent_type_next  = ent_type;
    ent_pid_next   = ent_pid;
    skip_next      = skip;
    count_next     = count;
    tt_next        = tt;
    push           = '0;

    if (fire) begin
      if (section_start) begin
        hdr_next          = '0;
        hdr_next.tbl_id   = data_byte;
        total_len_next    = '0;
        pil_next          = '0;
        ent_type_next     = '0;
        ent_pid_next      = '0;
        skip_next         = '0;
        count_next        = '0;
        tt_next           = 1'b0;
        offset_next       = 12'd1;
        phase_next        = pmt_pkg::PH_HEADER;
      end else if (phase != pmt_pkg::PH_IDLE) begin
        offset_next = (offset == pmt_pkg::OFS_MAX) ? offset : offset + 12'd1;
        case (phase)
          pmt_pkg::PH_HEADER: begin
            case (offset)
              pmt_pkg::OFS_LEN_HI:  total_len_next = {data_byte[3:0], 8'h00};
              pmt_pkg::OFS_LEN_LO:  total_len_next = {total_len[11:8], data_byte};
              pmt_pkg::OFS_PROG_HI: hdr_next.prog_num = {data_byte, 8'h00};
              pmt_pkg::OFS_PROG_LO: begin
                hdr_next.prog_num = {hdr.prog_num[15:8], data_byte};
              end
              pmt_pkg::OFS_VERSION: begin
                hdr_next.ver_num      = data_byte[5:1];
                hdr_next.current_next = data_byte[0];
              end
              pmt_pkg::OFS_SECTION: hdr_next.sec_num = data_byte;
              pmt_pkg::OFS_LAST:    hdr_next.last_sec_num = data_byte;
              pmt_pkg::OFS_PCR_HI:  hdr_next.pcr_pid = {data_byte[4:0], 8'h00};
              pmt_pkg::OFS_PCR_LO:  hdr_next.pcr_pid = {hdr.pcr_pid[12:8], data_byte};
              pmt_pkg::OFS_PIL_HI:  pil_next = {data_byte[3:0], 8'h00};
              default: begin
                // Last header byte: first entry would start at 12 + program info
                pil_next = pil_full;
                if (({1'b0, pil_full} + 13'd13) >= {1'b0, total_len}) begin
                  push.first = 1'b1;
                  push.a     = pmt_pkg::make_result(pmt_pkg::KIND_SUMMARY, hdr.tbl_id,
                                 hdr.pcr_pid, pil_full, hdr, total_len, count, tt);
                  phase_next = pmt_pkg::PH_IDLE;
                end else if (pil_full == 12'd0) begin
                  phase_next = pmt_pkg::PH_TYPE;
                end else begin
                  skip_next  = pil_full;
                  phase_next = pmt_pkg::PH_SKIP;
                end
              end
            endcase
          end
          pmt_pkg::PH_TYPE: begin
            ent_type_next = data_byte;
            phase_next    = pmt_pkg::PH_PID_HI;
          end
          pmt_pkg::PH_PID_HI: begin
            ent_pid_next = {data_byte[4:0], 8'h00};
            phase_next   = pmt_pkg::PH_PID_LO;
          end
          pmt_pkg::PH_PID_LO: begin
            ent_pid_next = {ent_pid[12:8], data_byte};
            phase_next   = pmt_pkg::PH_LEN_HI;
          end
          pmt_pkg::PH_LEN_HI: begin
            skip_next  = {data_byte[3:0], 8'h00};
            phase_next = pmt_pkg::PH_LEN_LO;
          end
          pmt_pkg::PH_LEN_LO: begin
            skip_next  = es_len;
            count_next = count_inc;
            push.first = 1'b1;
            push.a     = pmt_pkg::make_result(pmt_pkg::KIND_ENTRY, ent_type, ent_pid,
                           es_len, hdr, total_len, count_inc, tt);
            if (es_len == 12'd0) begin
              phase_next = pmt_pkg::PH_TYPE;
              // No descriptors: loop ends here if the next entry would not fit
              if (({1'b0, offset} + 13'd2) >= {1'b0, total_len}) begin
                push.second = 1'b1;
                push.b      = pmt_pkg::make_result(pmt_pkg::KIND_SUMMARY, hdr.tbl_id,
                                hdr.pcr_pid, pil, hdr, total_len, count_inc, tt);
                phase_next  = pmt_pkg::PH_IDLE;
              end
            end else begin
              phase_next = pmt_pkg::PH_DESC;
            end
          end
          pmt_pkg::PH_DESC: begin
            tt_next    = tt_new;
            skip_next  = skip_dec;
            phase_next = (skip_dec != 12'd0) ? pmt_pkg::PH_SKIP : pmt_pkg::PH_TYPE;
            if (({1'b0, offset} + {1'b0, skip} + 13'd1) >= {1'b0, total_len}) begin
              push.first = 1'b1;
              push.a     = pmt_pkg::make_result(pmt_pkg::KIND_SUMMARY, hdr.tbl_id,
                             hdr.pcr_pid, pil, hdr, total_len, count, tt_new);
              phase_next = pmt_pkg::PH_IDLE;
            end
          end
          pmt_pkg::PH_SKIP: begin
            skip_next = skip_dec;
            if (skip_dec == 12'd0) begin
              phase_next = pmt_pkg::PH_TYPE;
            end
          end
          default: phase_next = phase;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag    <= pmt_pkg::TELETEXT_TAG_RESET;
      phase  <= pmt_pkg::PH_IDLE;
      offset <= '0;
      count  <= '0;
      tt     <= 1'b0;
    end else begin
      if (cfg_we) begin
        tag <= cfg_data;
      end
      phase  <= phase_next;
      offset <= offset_next;
      count  <= count_next;
      tt     <= tt_next;
    end
  end

  always_ff @(posedge clk) begin
    total_len <= total_len_next;
    pil       <= pil_next;
    hdr       <= hdr_next;
    ent_type  <= ent_type_next;
    ent_pid   <= ent_pid_next;
    skip      <= skip_next;
  end

  a_summary_idles: assert property (@(posedge clk) disable iff (rst)
    (push.second || (push.first && push.a.item_kind == pmt_pkg::KIND_SUMMARY))
    |=> phase == pmt_pkg::PH_IDLE)
    else $error("summary issued but parser did not go idle");

  a_quiet_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == pmt_pkg::PH_IDLE || (fire && section_start)) |-> !push.first)
    else $error("result produced while idle or on section start");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.second |-> (push.first && push.a.item_kind == pmt_pkg::KIND_ENTRY &&
                     push.b.item_kind == pmt_pkg::KIND_SUMMARY))
    else $error("second result is not a summary after an entry");

endmodule

[design/pmt_result_queue.sv]
// ----------------------------------------------------------------------------
// pmt_result_queue: small result queue with two write slots per cycle
// Decouples the parse core from output backpressure.
// ----------------------------------------------------------------------------
module pmt_result_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  pmt_pkg::push_t       push,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pmt_pkg::result_t     out_item
);

  pmt_pkg::result_t             mem [pmt_pkg::QDEPTH];
  logic [pmt_pkg::QPTR_W-1:0]   wp;
  logic [pmt_pkg::QPTR_W-1:0]   rp;
  logic [pmt_pkg::QCNT_W-1:0]   count;
  logic                         pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rp];
  // Keep space for a full pair of results
  assign room      = (count <= pmt_pkg::QCNT_W'(pmt_pkg::QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wp] <= push.a;
    end
    if (push.second) begin
      mem[wp + pmt_pkg::QPTR_W'(1)] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + pmt_pkg::QPTR_W'(push.first) + pmt_pkg::QPTR_W'(push.second);
      rp    <= rp + pmt_pkg::QPTR_W'(pop);
      count <= count + pmt_pkg::QCNT_W'(push.first) + pmt_pkg::QCNT_W'(push.second)
               - pmt_pkg::QCNT_W'(pop);
    end
  end

  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    push.first |-> count <= pmt_pkg::QCNT_W'(pmt_pkg::QDEPTH - 2))
    else $error("push into queue without room for a pair");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pmt_pkg::QCNT_W'(pmt_pkg::QDEPTH))
    else $error("queue count beyond depth");

endmodule

[design/pmt_section_parser.sv]
// ----------------------------------------------------------------------------
// pmt_section_parser: byte-serial MPEG-TS program map section parser
// Registers each byte, decodes it against the section state, and queues
// stream entry and section summary results for the output channel.
// ----------------------------------------------------------------------------
// Path: the byte that completes a result is accepted into the input register;
//   when the core consumes it, the result is written into the result queue.
// Throughput: 1 byte per cycle sustained; the input stalls only while the
//   four-entry result queue holds more than two results.
// Reset: synchronous; the parser idles until a section start byte, the
//   teletext tag returns to 0x56 and the result queue empties.
module pmt_section_parser (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  // byte request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        section_start,
  // result request channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        item_kind,
  output logic [7:0]  type_or_tid,
  output logic [12:0] pid,
  output logic [11:0] info_length,
  output logic [15:0] prog_num,
  output logic [4:0]  ver_num,
  output logic        current_next,
  output logic [7:0]  sec_num,
  output logic [7:0]  last_sec_num,
  output logic [11:0] sect_len,
  output logic [7:0]  stream_count,
  output logic        teletext_found
);

  // Input register: holds one accepted byte until the core consumes it
  logic               s_valid;
  logic [7:0]         s_byte;
  logic               s_start;

  logic               room;
  logic               fire;
  logic               in_take;
  pmt_pkg::push_t     push;
  pmt_pkg::result_t   out_item;

  // Advance the held byte whenever the queue can absorb a pair of results
  assign fire     = s_valid && room;
  assign in_ready = !s_valid || room;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_take) begin
      s_valid <= 1'b1;
    end else if (fire) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s_byte  <= data_byte;
      s_start <= section_start;
    end
  end

  // Header capture, entry decode, descriptor skip and loop end detection
  pmt_parse_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .fire          (fire),
    .data_byte     (s_byte),
    .section_start (s_start),
    .push          (push)
  );

  // Results wait here for the downstream side
  pmt_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  assign item_kind      = out_item.item_kind;
  assign type_or_tid    = out_item.type_or_tid;
  assign pid            = out_item.pid;
  assign info_length    = out_item.info_length;
  assign prog_num       = out_item.prog_num;
  assign ver_num        = out_item.ver_num;
  assign current_next   = out_item.current_next;
  assign sec_num        = out_item.sec_num;
  assign last_sec_num   = out_item.last_sec_num;
  assign sect_len       = out_item.sect_len;
  assign stream_count   = out_item.stream_count;
  assign teletext_found = out_item.teletext_found;

endmodule

[tb/tb_pmt_section_parser.sv]
// ----------------------------------------------------------------------------
// tb_pmt_section_parser: self-checking bench for the program map section parser
// Streams program map sections byte by byte into the parser. A scoreboard
// class predicts every stream entry and section summary and checks the
// results in order, under random idling on both channels and a long
// receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pmt_section_parser;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TICKS = 8;
  localparam int HOLD_TICKS   = 400;
  localparam int PHASE_BYTES  = 120;

  // Parser position inside a section: entry bytes, descriptors, header
  typedef enum logic [7:0] {
    ST_TYPE   = 8'b00000001,
    ST_PID_HI = 8'b00000010,
    ST_PID_LO = 8'b00000100,
    ST_LEN_HI = 8'b00001000,
    ST_LEN_LO = 8'b00010000,
    ST_DESC   = 8'b00100000,
    ST_SKIP   = 8'b01000000,
    ST_HEADER = 8'b10000000
  } parse_step_t;

  // Scoreboard: tracks the section state, predicts results, checks them
  class pmt_parse_scoreboard;
    logic [7:0]       tag;
    logic [11:0]      ofs;
    logic [11:0]      sec_len;
    logic [11:0]      pil;
    logic [11:0]      skip;
    pmt_pkg::hdr_t    hdr;
    parse_step_t      step;
    logic [7:0]       stype;
    logic [12:0]      epid;
    logic [7:0]       count;
    logic             tt;
    logic             closed;
    pmt_pkg::result_t expected_results[$];
    int               errors;

    function new();
      tag     = pmt_pkg::TELETEXT_TAG_RESET;
      ofs     = '0;
      sec_len = '0;
      pil     = '0;
      skip    = '0;
      hdr     = '0;
      step    = ST_TYPE;
      stype   = '0;
      epid    = '0;
      count   = '0;
      tt      = 1'b0;
      closed  = 1'b1;
      errors  = 0;
    endfunction

    // An entry starting at position p lies before the loop end
    function bit before_loop_end(int p);
      return p + 1 < int'(sec_len);
    endfunction

    function void queue_result(logic kind, logic [7:0] id, logic [12:0] p, logic [11:0] len);
      pmt_pkg::result_t r;
      r.item_kind      = kind;
      r.type_or_tid    = id;
      r.pid            = p;
      r.info_length    = len;
      r.prog_num       = hdr.prog_num;
      r.ver_num        = hdr.ver_num;
      r.current_next   = hdr.current_next;
      r.sec_num        = hdr.sec_num;
      r.last_sec_num   = hdr.last_sec_num;
      r.sect_len       = sec_len;
      r.stream_count   = count;
      r.teletext_found = tt;
      expected_results.push_back(r);
    endfunction

    function void close_loop();
      queue_result(pmt_pkg::KIND_SUMMARY, hdr.tbl_id, hdr.pcr_pid, pil);
      closed = 1'b1;
    endfunction

    // Advance the section state by one accepted byte; 1 if the parser used it
    function bit accept_byte(logic [7:0] b, logic s);
      int cur;
      int nxt;
      if (s) begin
        hdr        = '0;
        hdr.tbl_id = b;
        sec_len    = '0;
        pil        = '0;
        stype      = '0;
        epid       = '0;
        skip       = '0;
        count      = '0;
        tt         = 1'b0;
        ofs        = 12'd1;
        step       = ST_HEADER;
        closed     = 1'b0;
        return 1'b1;
      end
      if (closed)
        return 1'b0;
      cur = int'(ofs);
      ofs = (ofs != pmt_pkg::OFS_MAX) ? ofs + 12'd1 : pmt_pkg::OFS_MAX;
      case (step)
        ST_HEADER: begin
          case (12'(cur))
            pmt_pkg::OFS_LEN_HI:  sec_len = {b[3:0], 8'h00};
            pmt_pkg::OFS_LEN_LO:  sec_len[7:0] = b;
            pmt_pkg::OFS_PROG_HI: hdr.prog_num[15:8] = b;
            pmt_pkg::OFS_PROG_LO: hdr.prog_num[7:0] = b;
            pmt_pkg::OFS_VERSION: begin
              hdr.ver_num      = b[5:1];
              hdr.current_next = b[0];
            end
            pmt_pkg::OFS_SECTION: hdr.sec_num = b;
            pmt_pkg::OFS_LAST:    hdr.last_sec_num = b;
            pmt_pkg::OFS_PCR_HI:  hdr.pcr_pid = {b[4:0], 8'h00};
            pmt_pkg::OFS_PCR_LO:  hdr.pcr_pid[7:0] = b;
            pmt_pkg::OFS_PIL_HI:  pil = {b[3:0], 8'h00};
            default: begin
              pil[7:0] = b;
              nxt = 12 + int'(pil);
              if (!before_loop_end(nxt))
                close_loop();
              else if (pil == 12'd0)
                step = ST_TYPE;
              else begin
                skip = pil;
                step = ST_SKIP;
              end
            end
          endcase
        end
        ST_SKIP: begin
          skip = skip - 12'd1;
          if (skip == 12'd0)
            step = ST_TYPE;
        end
        ST_TYPE: begin
          stype = b;
          step  = ST_PID_HI;
        end
        ST_PID_HI: begin
          epid = {b[4:0], 8'h00};
          step = ST_PID_LO;
        end
        ST_PID_LO: begin
          epid[7:0] = b;
          step      = ST_LEN_HI;
        end
        ST_LEN_HI: begin
          skip = {b[3:0], 8'h00};
          step = ST_LEN_LO;
        end
        ST_LEN_LO: begin
          skip[7:0] = b;
          if (count != 8'hFF)
            count = count + 8'd1;
          queue_result(pmt_pkg::KIND_ENTRY, stype, epid, skip);
          if (skip == 12'd0) begin
            step = ST_TYPE;
            if (!before_loop_end(cur + 1))
              close_loop();
          end else
            step = ST_DESC;
        end
        default: begin
          if (b == tag)
            tt = 1'b1;
          nxt  = cur + int'(skip);
          skip = skip - 12'd1;
          step = (skip != 12'd0) ? ST_SKIP : ST_TYPE;
          if (!before_loop_end(nxt))
            close_loop();
        end
      endcase
      return 1'b1;
    endfunction

    function void cmp_field(string name, logic [31:0] e, logic [31:0] a);
      if (a !== e) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(pmt_pkg::result_t got);
      pmt_pkg::result_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, actual 0x%0h", $time, got);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      cmp_field("item_kind", 32'(e.item_kind), 32'(got.item_kind));
      cmp_field("type_or_tid", 32'(e.type_or_tid), 32'(got.type_or_tid));
      cmp_field("pid", 32'(e.pid), 32'(got.pid));
      cmp_field("info_length", 32'(e.info_length), 32'(got.info_length));
      cmp_field("prog_num", 32'(e.prog_num), 32'(got.prog_num));
      cmp_field("ver_num", 32'(e.ver_num), 32'(got.ver_num));
      cmp_field("current_next", 32'(e.current_next), 32'(got.current_next));
      cmp_field("sec_num", 32'(e.sec_num), 32'(got.sec_num));
      cmp_field("last_sec_num", 32'(e.last_sec_num), 32'(got.last_sec_num));
      cmp_field("sect_len", 32'(e.sect_len), 32'(got.sect_len));
      cmp_field("stream_count", 32'(e.stream_count), 32'(got.stream_count));
      cmp_field("teletext_found", 32'(e.teletext_found), 32'(got.teletext_found));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        section_start;
  logic        out_valid;
  logic        out_ready;
  logic        item_kind;
  logic [7:0]  type_or_tid;
  logic [12:0] pid;
  logic [11:0] info_length;
  logic [15:0] prog_num;
  logic [4:0]  ver_num;
  logic        current_next;
  logic [7:0]  sec_num;
  logic [7:0]  last_sec_num;
  logic [11:0] sect_len;
  logic [7:0]  stream_count;
  logic        teletext_found;

  pmt_parse_scoreboard sb;

  // Idle rates in percent for each side; the test sequence changes them
  int send_idle;
  int recv_idle;
  // Long receiver hold-off: raised by the sequence, consumed by the receiver
  bit hold_request;
  int hold_left;
  int cycles;
  int live_bytes;

  pmt_section_parser DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .section_start  (section_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .item_kind      (item_kind),
    .type_or_tid    (type_or_tid),
    .pid            (pid),
    .info_length    (info_length),
    .prog_num       (prog_num),
    .ver_num        (ver_num),
    .current_next   (current_next),
    .sec_num        (sec_num),
    .last_sec_num   (last_sec_num),
    .sect_len       (sect_len),
    .stream_count   (stream_count),
    .teletext_found (teletext_found)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run; the limit covers every phase at its slowest idling
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               sb.expected_results.size());
      $display("FAIL pmt_section_parser");
      $finish;
    end
  end

  // Result side: check each accepted result, then pick next cycle's ready.
  // A pending hold request turns into a long stretch of ready low, counted here.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        sb.check_result({item_kind, type_or_tid, pid, info_length, prog_num,
                         ver_num, current_next, sec_num, last_sec_num, sect_len,
                         stream_count, teletext_found});
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_TICKS;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Offer one byte request, idling first at random; return at the accepting edge
  task automatic send_byte(input logic [7:0] b, input logic s);
    if (int'($urandom_range(99)) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    section_start <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.accept_byte(b, s))
      live_bytes++;
  endtask

  // Send a byte run whose first byte carries the section start
  task automatic send_run(input logic [7:0] bytes[$]);
    foreach (bytes[i])
      send_byte(bytes[i], i == 0);
  endtask

  // Build a well-formed section with random content: program info bytes,
  // n_ent stream entries with ES info lengths up to es_max, a section length
  // that closes the loop after the last entry (moved by up to +/- jitter),
  // then four CRC bytes. Now and then cut the section short.
  task automatic send_section(input int pil, input int n_ent, input int es_max,
                              input int jitter);
    logic [7:0] bytes[$];
    int es;
    int len;
    bytes = {};
    bytes.push_back(8'($urandom));
    bytes.push_back(8'h00);
    bytes.push_back(8'h00);
    repeat (7) bytes.push_back(8'($urandom));
    bytes.push_back({4'($urandom), 4'(pil >> 8)});
    bytes.push_back(8'(pil));
    // Skip bytes past the loop end are ignored, so hold back a huge info block
    repeat ((pil > 1000) ? 4 : pil) bytes.push_back(8'($urandom));
    repeat (n_ent) begin
      es = $urandom_range(es_max, 0);
      bytes.push_back(8'($urandom));
      bytes.push_back({3'($urandom), 5'($urandom)});
      bytes.push_back(8'($urandom));
      bytes.push_back({4'($urandom), 4'(es >> 8)});
      bytes.push_back(8'(es));
      for (int d = 0; d < es; d++)
        bytes.push_back((d == 0 && $urandom_range(2) == 0) ? sb.tag : 8'($urandom));
    end
    len = bytes.size() + 1;
    if (jitter > 0)
      len = len + $urandom_range(2 * jitter) - jitter;
    if (len < 0)
      len = 0;
    if (len > 4095)
      len = 4095;
    bytes[1] = {4'($urandom), 4'(len >> 8)};
    bytes[2] = 8'(len);
    repeat (4) bytes.push_back(8'($urandom));
    if ($urandom_range(11) == 0)
      bytes = bytes[0:$urandom_range(bytes.size() - 1)];
    send_run(bytes);
  endtask

  // Drop valid, wait until every predicted result is back, then let the
  // pipeline settle in case the last bytes are still in flight
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_tag(input logic [7:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.tag = v;
  endtask

  // One random phase: mostly sections, some noise, one long info block
  task automatic random_phase();
    int target;
    target = live_bytes + PHASE_BYTES;
    send_section($urandom_range(80, 30), 2, 4, 0);
    while (live_bytes < target) begin
      case ($urandom_range(9))
        0: repeat ($urandom_range(6, 1))
             send_byte(8'($urandom), $urandom_range(15) == 0);
        1: send_section($urandom_range(3), $urandom_range(5), 6, 6);
        default: send_section(($urandom_range(2) == 0) ? $urandom_range(3) : 0,
                              $urandom_range(5), $urandom_range(6), 0);
      endcase
    end
  endtask

  initial begin
    sb            = new();
    send_idle     = 0;
    recv_idle     = 0;
    hold_request  = 1'b0;
    hold_left     = 0;
    cycles        = 0;
    live_bytes    = 0;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_data      <= 8'h00;
    in_valid      <= 1'b0;
    data_byte     <= 8'h00;
    section_start <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Idle parser: bytes before any section start are dropped
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // Zero section length, section number and info length, other header bits set: summary on byte 11
    send_run('{8'h02, 8'hF0, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF,
               8'hF0, 8'h00});
    send_byte(8'hA5, 1'b0);
    // Restart in the middle of a header
    send_run('{8'h02, 8'hB0, 8'h1A, 8'h12});
    // One info byte, a teletext entry, then an entry with no descriptors
    // that closes the loop: entry and summary on the same byte
    send_run('{8'h02, 8'hB0, 8'h1A, 8'h00, 8'h01, 8'hC1, 8'h00, 8'h00, 8'hE1, 8'h00,
               8'hF0, 8'h01, 8'h77,
               8'h00, 8'hFF, 8'hFF, 8'hF0, 8'h02, pmt_pkg::TELETEXT_TAG_RESET, 8'h00,
               8'hFF, 8'hE0, 8'h00, 8'hF0, 8'h00,
               8'hDE, 8'hAD, 8'hBE, 8'hEF});

    // Sender mostly busy, receiver mostly stalled
    write_tag(8'h00);
    send_idle = 8;
    recv_idle = 70;
    // Program info length at its maximum closes the loop at once
    send_section(4095, 0, 0, 0);
    random_phase();

    // Sender mostly idle, receiver mostly ready
    write_tag(8'hFF);
    send_idle = 70;
    recv_idle = 8;
    random_phase();

    // No idling; hold the receiver off while a long section fills the queue
    write_tag(8'($urandom));
    send_idle    = 0;
    recv_idle    = 0;
    hold_request = 1'b1;
    send_section(0, 20, 0, 0);
    random_phase();
    drain();

    if (sb.errors == 0 && sb.expected_results.size() == 0)
      $display("PASS pmt_section_parser");
    else
      $display("FAIL pmt_section_parser");
    $finish;
  end

endmodule
